// File: rtl/orl_pkg.sv
// Shared constants, types and the command format of the overwriting ring log.
// Used by every module of the block except orl_ram; depends on nothing.
package orl_pkg;

    localparam int RING_DEPTH = 64;
    localparam int ENTRY_BITS = 64;

    localparam int DATA_W  = 64;
    localparam int CFG_W   = 7;
    localparam int COUNT_W = 6;
    localparam int OVR_W   = 32;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int SLOT_W  = $clog2(RING_DEPTH + 1);
    localparam int CLAMP_W = (SLOT_W > CFG_W) ? SLOT_W : CFG_W;
    localparam int CMP_W   = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [ENTRY_BITS-1:0] entry;
        logic [COUNT_W-1:0]    want;
    } t_cmd;

    typedef struct packed {
        logic             has_entry;
        logic             last;
        logic             dropped;
        logic [OVR_W-1:0] overrun;
        logic [PTR_W-1:0] held;
    } t_result_meta;

    typedef enum logic {
        BK_DISPATCH = 1'b0,
        BK_READ     = 1'b1
    } t_bk_state;

endpackage

// File: rtl/overwriting_ring_log.sv
// Overwriting trace log ring: top level joining the front end queue and the back end.
// Depends on orl_pkg, orl_front, orl_back and orl_ram.
// An accepted transaction is registered in the command queue, in s1 and in the output
// register in turn. Writes go one per cycle unless the output stalls or a read is busy;
// a read is paced by the entry store's single read port. Synchronous active-low reset
// empties the ring, clears the overrun counter and sets the slot count to the full depth.
module overwriting_ring_log (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [orl_pkg::DATA_W-1:0]     i_entry_in,
    input  logic [orl_pkg::COUNT_W-1:0]    i_read_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [orl_pkg::DATA_W-1:0]     o_entry_out,
    output logic                           o_has_entry,
    output logic                           o_last,
    output logic                           o_dropped_oldest,
    output logic [orl_pkg::OVR_W-1:0]      o_overrun_total,
    output logic [orl_pkg::COUNT_W-1:0]    o_entries_held,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [orl_pkg::CFG_W-1:0]      i_cfg_slots_in_use
);

    logic          cmd_valid;
    orl_pkg::t_cmd cmd;
    logic          cmd_pop;
    logic          front_empty;
    logic          back_idle;

    orl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_entry_in   (i_entry_in),
        .i_read_count (i_read_count),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop),
        .o_empty      (front_empty)
    );

    orl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (cmd),
        .o_cmd_pop        (cmd_pop),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_slots      (i_cfg_slots_in_use),
        .o_idle           (back_idle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_entry_out      (o_entry_out),
        .o_has_entry      (o_has_entry),
        .o_last           (o_last),
        .o_dropped_oldest (o_dropped_oldest),
        .o_overrun_total  (o_overrun_total),
        .o_entries_held   (o_entries_held)
    );

    assign o_cfg_ready = front_empty && back_idle;

endmodule

// File: rtl/orl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module orl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/orl_front.sv
// Front end: accepts input transactions, classifies them into commands and
// queues them for the back end. Depends on orl_pkg.
module orl_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [orl_pkg::DATA_W-1:0]     i_entry_in,
    input  logic [orl_pkg::COUNT_W-1:0]    i_read_count,
    output logic                           o_cmd_valid,
    output orl_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_pop,
    output logic                           o_empty
);

    orl_pkg::t_cmd                       r_q [orl_pkg::CMDQ_DEPTH];
    logic [orl_pkg::CMDQ_PTR_W-1:0]      r_wr, n_wr;
    logic [orl_pkg::CMDQ_PTR_W-1:0]      r_rd, n_rd;
    logic [orl_pkg::CMDQ_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                push;
    logic                                pop;
    orl_pkg::t_cmd                       cmd_in;

    function automatic logic [orl_pkg::CMDQ_PTR_W-1:0] qwrap(
        input logic [orl_pkg::CMDQ_PTR_W-1:0] p
    );
        if (32'(p) == orl_pkg::CMDQ_DEPTH - 1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        cmd_in.op    = i_operation ? orl_pkg::OP_READ : orl_pkg::OP_WRITE;
        cmd_in.entry = i_entry_in[orl_pkg::ENTRY_BITS-1:0];
        cmd_in.want  = i_read_count;
    end

    assign o_stall     = (32'(r_cnt) == orl_pkg::CMDQ_DEPTH);
    assign o_empty     = (r_cnt == '0);
    assign o_cmd_valid = !o_empty;
    assign o_cmd       = r_q[r_rd];
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr  = push ? qwrap(r_wr) : r_wr;
        n_rd  = pop ? qwrap(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

// File: rtl/orl_back.sv
// Back end: carries out queued commands against the ring store, keeps the
// pointers and counters, and drives the result stage. Depends on orl_pkg, orl_ram.
module orl_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  orl_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    input  logic                           i_cfg_we,
    input  logic [orl_pkg::CFG_W-1:0]      i_cfg_slots,
    output logic                           o_idle,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [orl_pkg::DATA_W-1:0]     o_entry_out,
    output logic                           o_has_entry,
    output logic                           o_last,
    output logic                           o_dropped_oldest,
    output logic [orl_pkg::OVR_W-1:0]      o_overrun_total,
    output logic [orl_pkg::COUNT_W-1:0]    o_entries_held
);

    orl_pkg::t_bk_state                 r_state, n_state;
    logic [orl_pkg::PTR_W-1:0]          r_rp, n_rp;
    logic [orl_pkg::PTR_W-1:0]          r_wp, n_wp;
    logic [orl_pkg::PTR_W-1:0]          r_held, n_held;
    logic [orl_pkg::PTR_W-1:0]          r_remain, n_remain;
    logic [orl_pkg::OVR_W-1:0]          r_overrun, n_overrun;
    logic [orl_pkg::SLOT_W-1:0]         r_slots;
    logic                               r_s1_valid;
    orl_pkg::t_result_meta              r_s1;
    logic                               r_o_valid;
    orl_pkg::t_result_meta              r_o;
    logic [orl_pkg::DATA_W-1:0]         r_o_entry;

    logic                               s2_load;
    logic                               s1_free;
    logic                               s1_load;
    orl_pkg::t_result_meta              meta;
    logic                               ram_we;
    logic                               ram_re;
    logic [orl_pkg::ENTRY_BITS-1:0]     ram_rdata;
    logic [orl_pkg::PTR_W-1:0]          count;
    logic                               full;
    logic [orl_pkg::CLAMP_W-1:0]        cfg_wide;
    logic [orl_pkg::SLOT_W-1:0]         cfg_slots;

    function automatic logic [orl_pkg::PTR_W-1:0] pwrap(
        input logic [orl_pkg::PTR_W-1:0]  p,
        input logic [orl_pkg::SLOT_W-1:0] n
    );
        if (orl_pkg::SLOT_W'(p) == n - 1'b1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    orl_ram #(
        .WIDTH (orl_pkg::ENTRY_BITS),
        .DEPTH (orl_pkg::RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.entry),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cfg_wide = orl_pkg::CLAMP_W'(i_cfg_slots);
        if (cfg_wide < orl_pkg::CLAMP_W'(2)) begin
            cfg_slots = orl_pkg::SLOT_W'(2);
        end else if (cfg_wide > orl_pkg::CLAMP_W'(orl_pkg::RING_DEPTH)) begin
            cfg_slots = orl_pkg::SLOT_W'(orl_pkg::RING_DEPTH);
        end else begin
            cfg_slots = orl_pkg::SLOT_W'(cfg_wide);
        end
    end

    assign s2_load = r_s1_valid && (!r_o_valid || !i_stall);
    assign s1_free = !r_s1_valid || s2_load;
    assign full    = (orl_pkg::SLOT_W'(r_held) == r_slots - 1'b1);
    assign count   = (orl_pkg::CMP_W'(i_cmd.want) < orl_pkg::CMP_W'(r_held))
                     ? orl_pkg::PTR_W'(i_cmd.want) : r_held;

    always_comb begin
        n_state = r_state;
        case (r_state)
            orl_pkg::BK_DISPATCH: begin
                if (s1_free && i_cmd_valid && i_cmd.op == orl_pkg::OP_READ
                        && count > orl_pkg::PTR_W'(1)) begin
                    n_state = orl_pkg::BK_READ;
                end
            end
            orl_pkg::BK_READ: begin
                if (s1_free && r_remain == orl_pkg::PTR_W'(1)) begin
                    n_state = orl_pkg::BK_DISPATCH;
                end
            end
            default: n_state = orl_pkg::BK_DISPATCH;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        s1_load   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        meta      = '0;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_held    = r_held;
        n_remain  = r_remain;
        n_overrun = r_overrun;
        case (r_state)
            orl_pkg::BK_DISPATCH: begin
                if (s1_free && i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    s1_load   = 1'b1;
                    meta.last = 1'b1;
                    if (i_cmd.op == orl_pkg::OP_WRITE) begin
                        ram_we = 1'b1;
                        n_wp   = pwrap(r_wp, r_slots);
                        if (full) begin
                            n_rp         = pwrap(r_rp, r_slots);
                            n_overrun    = r_overrun + 1'b1;
                            meta.dropped = 1'b1;
                        end else begin
                            n_held = r_held + 1'b1;
                        end
                    end else if (count != '0) begin
                        ram_re         = 1'b1;
                        n_rp           = pwrap(r_rp, r_slots);
                        n_held         = r_held - count;
                        n_remain       = count - 1'b1;
                        meta.has_entry = 1'b1;
                        meta.last      = (count == orl_pkg::PTR_W'(1));
                    end
                    meta.overrun = n_overrun;
                    meta.held    = n_held;
                end
            end
            orl_pkg::BK_READ: begin
                if (s1_free) begin
                    s1_load        = 1'b1;
                    ram_re         = 1'b1;
                    n_rp           = pwrap(r_rp, r_slots);
                    n_remain       = r_remain - 1'b1;
                    meta.has_entry = 1'b1;
                    meta.last      = (r_remain == orl_pkg::PTR_W'(1));
                    meta.overrun   = r_overrun;
                    meta.held      = r_held;
                end
            end
            default: begin
                meta = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= orl_pkg::BK_DISPATCH;
            r_rp       <= '0;
            r_wp       <= '0;
            r_held     <= '0;
            r_remain   <= '0;
            r_overrun  <= '0;
            r_slots    <= orl_pkg::SLOT_W'(orl_pkg::RING_DEPTH);
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_remain  <= n_remain;
            r_overrun <= n_overrun;
            if (i_cfg_we) begin
                r_slots <= cfg_slots;
                r_rp    <= '0;
                r_wp    <= '0;
                r_held  <= '0;
            end else begin
                r_rp   <= n_rp;
                r_wp   <= n_wp;
                r_held <= n_held;
            end
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (s1_load) begin
            r_s1 <= meta;
        end
        if (s2_load) begin
            r_o       <= r_s1;
            r_o_entry <= r_s1.has_entry ? orl_pkg::DATA_W'(ram_rdata) : '0;
        end
    end

    assign o_idle           = (r_state == orl_pkg::BK_DISPATCH) && !r_s1_valid && !r_o_valid;
    assign o_valid          = r_o_valid;
    assign o_entry_out      = r_o_entry;
    assign o_has_entry      = r_o.has_entry;
    assign o_last           = r_o.last;
    assign o_dropped_oldest = r_o.dropped;
    assign o_overrun_total  = r_o.overrun;
    assign o_entries_held   = orl_pkg::COUNT_W'(r_o.held);

endmodule
